FILE: hw/rtl/terrain_block_generator_defines.svh
// Assertion macros for the terrain block generator checker.
`ifndef TERRAIN_BLOCK_GENERATOR_DEFINES_SVH
`define TERRAIN_BLOCK_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TBG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a delay set by the argument n.
`define TBG_ASSERT_DELAY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## n (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tbg_pkg.sv
// Types and constants of the terrain block generator.
package tbg_pkg;

  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Z = 32'd19349663;
  localparam logic [31:0] HASH_MUL_S = 32'd83492791;
  localparam logic [31:0] HASH_MUL_F = 32'd1274126177;
  localparam int unsigned HASH_SHIFT_A = 13;

  localparam logic signed [8:0] NOISE_MID = 9'sd128;

  // floor(v/3) for v < 768 and floor(v/6) for v < 512
  localparam logic [9:0] RECIP_3_6 = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;
  localparam int unsigned DIV6_SHIFT = 12;
  localparam logic [6:0] AMP_MIN = 7'd2;

  localparam logic [2:0] KIND_AIR     = 3'd0;
  localparam logic [2:0] KIND_BEDROCK = 3'd1;
  localparam logic [2:0] KIND_STONE   = 3'd2;
  localparam logic [2:0] KIND_DIRT    = 3'd3;
  localparam logic [2:0] KIND_GRASS   = 3'd4;
  localparam logic [2:0] KIND_SAND    = 3'd5;
  localparam logic [2:0] KIND_WATER   = 3'd6;

  localparam logic [1:0] CFG_SEED   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_LENGTH = 2'd3;

  localparam logic [15:0] SEED_RST   = 16'd0;
  localparam logic [8:0]  WIDTH_RST  = 9'd256;
  localparam logic [8:0]  HEIGHT_RST = 9'd64;
  localparam logic [8:0]  LENGTH_RST = 9'd256;

  // height shaping taken from world_height
  typedef struct packed {
    logic [7:0]  sea;
    logic [6:0]  amp;
    logic [10:0] hmax;   // world_height - 2, two's complement
  } tbg_hcfg_t;

endpackage

FILE: hw/rtl/tbg_lattice_hash.sv
// Two-stage lattice hash: coordinate mix, then the final multiply.
module tbg_lattice_hash (
  input  logic        clk,
  input  logic [5:0]  lat_x,
  input  logic [5:0]  lat_z,
  input  logic [31:0] seed_term,
  output logic [7:0]  lat_val
);
  import tbg_pkg::*;

  localparam logic [23:0] MUL_F_LO = HASH_MUL_F[23:0];

  logic [31:0] mix;
  logic [31:0] mix_sh;
  logic [23:0] mix_r;
  logic [23:0] mix_nxt;
  logic [47:0] prod;
  logic [23:0] prod_r;
  logic [23:0] prod_nxt;

  // only the low 24 bits of the final product reach the low byte
  assign mix     = ({26'd0, lat_x} * HASH_MUL_X) ^ ({26'd0, lat_z} * HASH_MUL_Z) ^ seed_term;
  assign mix_sh  = mix ^ (mix >> HASH_SHIFT_A);
  assign mix_nxt = mix_sh[23:0];

  assign prod     = {24'd0, mix_r} * {24'd0, MUL_F_LO};
  assign prod_nxt = prod[23:0];

  always_ff @(posedge clk) begin
    mix_r  <= mix_nxt;
    prod_r <= prod_nxt;
  end

  assign lat_val = prod_r[7:0] ^ prod_r[23:16];
endmodule

FILE: hw/rtl/tbg_noise.sv
// Bilinear interpolation of both octaves and the 2:1 blend.
module tbg_noise (
  input  logic            clk,
  input  logic [3:0][7:0] lat_coarse,  // 00, 10, 01, 11
  input  logic [3:0][7:0] lat_fine,
  input  logic [7:0]      coord_x,
  input  logic [7:0]      coord_z,
  output logic [7:0]      noise
);
  import tbg_pkg::*;

  logic [4:0]  fxc;
  logic [2:0]  fxf;
  logic [5:0]  wxc;
  logic [3:0]  wxf;
  logic [13:0] topc_r, botc_r, topc_nxt, botc_nxt;
  logic [10:0] topf_r, botf_r, topf_nxt, botf_nxt;
  logic [4:0]  fzc_r;
  logic [2:0]  fzf_r;
  logic [5:0]  wzc;
  logic [3:0]  wzf;
  logic [18:0] sumc;
  logic [14:0] sumf;
  logic [7:0]  vc_r, vf_r;
  logic [9:0]  blend;
  logic [19:0] blend_prod;
  logic [7:0]  noise_r;

  assign fxc = coord_x[4:0];
  assign fxf = coord_x[2:0];
  assign wxc = 6'd32 - {1'b0, fxc};
  assign wxf = 4'd8 - {1'b0, fxf};

  // interpolate along x
  assign topc_nxt = 14'(lat_coarse[0]) * 14'(wxc) + 14'(lat_coarse[1]) * 14'(fxc);
  assign botc_nxt = 14'(lat_coarse[2]) * 14'(wxc) + 14'(lat_coarse[3]) * 14'(fxc);
  assign topf_nxt = 11'(lat_fine[0]) * 11'(wxf) + 11'(lat_fine[1]) * 11'(fxf);
  assign botf_nxt = 11'(lat_fine[2]) * 11'(wxf) + 11'(lat_fine[3]) * 11'(fxf);

  // interpolate along z, then drop the grid-squared scale
  assign wzc  = 6'd32 - {1'b0, fzc_r};
  assign wzf  = 4'd8 - {1'b0, fzf_r};
  assign sumc = 19'(topc_r) * 19'(wzc) + 19'(botc_r) * 19'(fzc_r);
  assign sumf = 15'(topf_r) * 15'(wzf) + 15'(botf_r) * 15'(fzf_r);

  assign blend      = {1'b0, vc_r, 1'b0} + {2'b00, vf_r};
  assign blend_prod = 20'(blend) * 20'(RECIP_3_6);

  always_ff @(posedge clk) begin
    topc_r  <= topc_nxt;
    botc_r  <= botc_nxt;
    topf_r  <= topf_nxt;
    botf_r  <= botf_nxt;
    fzc_r   <= coord_z[4:0];
    fzf_r   <= coord_z[2:0];
    vc_r    <= sumc[17:10];
    vf_r    <= sumf[13:6];
    noise_r <= blend_prod[DIV3_SHIFT +: 8];
  end

  assign noise = noise_r;
endmodule

FILE: hw/rtl/tbg_height.sv
// Column height: scale around sea level, truncate, clamp.
module tbg_height (
  input  logic                clk,
  input  logic [7:0]          noise,
  input  tbg_pkg::tbg_hcfg_t  hcfg,
  output logic [10:0]         height
);
  import tbg_pkg::*;

  logic signed [8:0]  n_off;
  logic signed [7:0]  amp_s;
  logic signed [16:0] d_r;
  logic signed [16:0] d_nxt;
  logic signed [16:0] d_adj;
  logic signed [16:0] q;
  logic signed [10:0] h_raw;
  logic signed [10:0] h_lo;
  logic signed [10:0] hmax_s;
  logic signed [10:0] h_nxt;
  logic [10:0]        h_r;

  assign n_off = $signed({1'b0, noise}) - NOISE_MID;
  assign amp_s = $signed({1'b0, hcfg.amp});
  assign d_nxt = n_off * amp_s;

  // round toward zero: bias negatives before the arithmetic shift
  assign d_adj  = d_r + (d_r[16] ? 17'sd127 : 17'sd0);
  assign q      = d_adj >>> 7;
  assign h_raw  = $signed({3'b000, hcfg.sea}) + $signed(q[10:0]);
  assign hmax_s = $signed(hcfg.hmax);
  assign h_lo   = (h_raw < 11'sd1) ? 11'sd1 : h_raw;
  assign h_nxt  = (h_lo > hmax_s) ? hmax_s : h_lo;

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    h_r <= h_nxt;
  end

  assign height = h_r;
endmodule

FILE: hw/rtl/terrain_block_generator.sv
// Terrain block generator top level: config registers, pipeline control, layer rules.
// Throughput: one coordinate per cycle; busy is low whenever rst_n is high.
// Depth: hash multiply chain, two interpolation stages, the blend, the height math.
// Reset (synchronous, rst_n low): config registers go to defaults, in-flight items drop.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
module terrain_block_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_coord_x,
  input  logic [7:0]  in_coord_y,
  input  logic [7:0]  in_coord_z,
  output logic        out_valid,
  output logic [2:0]  out_block_kind,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import tbg_pkg::*;

  localparam int unsigned DEPTH = 7;

  logic [15:0] seed_r;
  logic [8:0]  world_width_r;
  logic [8:0]  world_height_r;
  logic [8:0]  world_length_r;

  logic        accept;
  logic [31:0] seed_term;
  logic        outside;
  logic [5:0]  lat_x [8];
  logic [5:0]  lat_z [8];
  logic [7:0]  lat_val [8];
  logic [3:0][7:0] lat_coarse;
  logic [3:0][7:0] lat_fine;
  logic [5:0]  cxc, czc, cxf, czf;

  logic [DEPTH-1:0] v_pipe_r;
  logic [7:0]  y_pipe_r [DEPTH];
  logic        out_pipe_r [DEPTH];
  logic [7:0]  x_pipe_r [2];
  logic [7:0]  z_pipe_r [2];

  logic [18:0] amp_prod;
  logic [6:0]  amp_raw;
  tbg_hcfg_t   hcfg_nxt;
  tbg_hcfg_t   hcfg_r;
  logic [7:0]  noise;
  logic [10:0] height;

  logic signed [10:0] ys;
  logic signed [10:0] hs;
  logic signed [10:0] sea_s;
  logic [2:0]  kind_nxt;
  logic        out_valid_r;
  logic [2:0]  out_kind_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r         <= SEED_RST;
      world_width_r  <= WIDTH_RST;
      world_height_r <= HEIGHT_RST;
      world_length_r <= LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED:   seed_r         <= cfg_wdata;
        CFG_WIDTH:  world_width_r  <= cfg_wdata[8:0];
        CFG_HEIGHT: world_height_r <= cfg_wdata[8:0];
        CFG_LENGTH: world_length_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign seed_term = {16'd0, seed_r} * HASH_MUL_S;
  assign outside   = ({1'b0, in_coord_x} >= world_width_r) ||
                     ({1'b0, in_coord_y} >= world_height_r) ||
                     ({1'b0, in_coord_z} >= world_length_r);

  // lattice corners: coarse cells of 32, fine cells of 8
  assign cxc = {3'b000, in_coord_x[7:5]};
  assign czc = {3'b000, in_coord_z[7:5]};
  assign cxf = {1'b0, in_coord_x[7:3]};
  assign czf = {1'b0, in_coord_z[7:3]};

  always_comb begin
    lat_x[0] = cxc;          lat_z[0] = czc;
    lat_x[1] = cxc + 6'd1;   lat_z[1] = czc;
    lat_x[2] = cxc;          lat_z[2] = czc + 6'd1;
    lat_x[3] = cxc + 6'd1;   lat_z[3] = czc + 6'd1;
    lat_x[4] = cxf;          lat_z[4] = czf;
    lat_x[5] = cxf + 6'd1;   lat_z[5] = czf;
    lat_x[6] = cxf;          lat_z[6] = czf + 6'd1;
    lat_x[7] = cxf + 6'd1;   lat_z[7] = czf + 6'd1;
  end

  for (genvar i = 0; i < 8; i++) begin : g_hash
    tbg_lattice_hash u_hash (
      .clk       (clk),
      .lat_x     (lat_x[i]),
      .lat_z     (lat_z[i]),
      .seed_term (seed_term),
      .lat_val   (lat_val[i])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_corner
    assign lat_coarse[i] = lat_val[i];
    assign lat_fine[i]   = lat_val[i+4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_pipe_r <= '0;
    end else begin
      v_pipe_r <= {v_pipe_r[DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    y_pipe_r[0]   <= in_coord_y;
    out_pipe_r[0] <= outside;
    x_pipe_r[0]   <= in_coord_x;
    z_pipe_r[0]   <= in_coord_z;
    x_pipe_r[1]   <= x_pipe_r[0];
    z_pipe_r[1]   <= z_pipe_r[0];
    for (int i = 1; i < DEPTH; i++) begin
      y_pipe_r[i]   <= y_pipe_r[i-1];
      out_pipe_r[i] <= out_pipe_r[i-1];
    end
  end

  tbg_noise u_noise (
    .clk        (clk),
    .lat_coarse (lat_coarse),
    .lat_fine   (lat_fine),
    .coord_x    (x_pipe_r[1]),
    .coord_z    (z_pipe_r[1]),
    .noise      (noise)
  );

  assign amp_prod      = 19'(world_height_r) * 19'(RECIP_3_6);
  assign amp_raw       = amp_prod[DIV6_SHIFT +: 7];
  assign hcfg_nxt.sea  = world_height_r[8:1];
  assign hcfg_nxt.amp  = (amp_raw < AMP_MIN) ? AMP_MIN : amp_raw;
  assign hcfg_nxt.hmax = {2'b00, world_height_r} - 11'd2;

  // hold the height shaping in a register, well ahead of the stages that use it
  always_ff @(posedge clk) begin
    hcfg_r <= hcfg_nxt;
  end

  tbg_height u_height (
    .clk    (clk),
    .noise  (noise),
    .hcfg   (hcfg_r),
    .height (height)
  );

  assign ys    = $signed({3'b000, y_pipe_r[DEPTH-1]});
  assign hs    = $signed(height);
  assign sea_s = $signed({3'b000, hcfg_r.sea});

  always_comb begin
    if (out_pipe_r[DEPTH-1]) begin
      kind_nxt = KIND_AIR;
    end else if (y_pipe_r[DEPTH-1] == 8'd0) begin
      kind_nxt = KIND_BEDROCK;
    end else if (ys > hs) begin
      kind_nxt = (y_pipe_r[DEPTH-1] <= hcfg_r.sea) ? KIND_WATER : KIND_AIR;
    end else if (ys == hs) begin
      kind_nxt = (hs < sea_s) ? KIND_SAND : KIND_GRASS;
    end else if (ys >= hs - 11'sd3) begin
      kind_nxt = KIND_DIRT;
    end else begin
      kind_nxt = KIND_STONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_pipe_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= kind_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_block_kind = out_kind_r;
endmodule

FILE: hw/rtl/tbg_checker.sv
// Port-level checker for the terrain block generator, bound to the top level.
`include "terrain_block_generator_defines.svh"

module tbg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_coord_y,
  input logic       out_valid,
  input logic [2:0] out_block_kind
);
  import tbg_pkg::*;

  `TBG_ASSERT_DELAY(a_latency, start && !busy, 8, out_valid, "transfer produced no result")
  `TBG_ASSERT_IMPLY(a_no_extra, out_valid, $past(start && !busy, 8), "result without transfer")
  `TBG_ASSERT_IMPLY(a_kind_range, out_valid, out_block_kind <= KIND_WATER, "bad block kind")
  `TBG_ASSERT_DELAY(a_floor, start && !busy && in_coord_y == 8'd0, 8, out_block_kind == KIND_AIR || out_block_kind == KIND_BEDROCK, "bottom layer not bedrock")
endmodule

bind terrain_block_generator tbg_checker u_tbg_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for the terrain block generator: random coordinates, live predictor.
`timescale 1ns / 1ps

module testbench;
  import tbg_pkg::*;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
  } coord_t;

  typedef struct {
    coord_t     at;
    logic [2:0] kind;
  } kind_due_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_coord_x = 8'd0;
  logic [7:0]  in_coord_y = 8'd0;
  logic [7:0]  in_coord_z = 8'd0;
  logic        out_valid;
  logic [2:0]  out_block_kind;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SEED;
  logic [15:0] cfg_wdata = 16'd0;

  // predictor's copy of the configuration
  int unsigned terrain_seed = SEED_RST;
  int          world_w = WIDTH_RST;
  int          world_h = HEIGHT_RST;
  int          world_l = LENGTH_RST;

  coord_t      coords_pending[$];
  kind_due_t   kinds_due[$];
  coord_t      next_coord;
  kind_due_t   due_now;
  int          sent_count = 0;
  int          mismatches = 0;

  terrain_block_generator uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z),
    .out_valid(out_valid),
    .out_block_kind(out_block_kind),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int lattice_byte(int lx, int lz);
    bit [31:0] h;
    h = 32'(lx[15:0]) * HASH_MUL_X;
    h ^= 32'(lz[15:0]) * HASH_MUL_Z;
    h ^= 32'(terrain_seed[15:0]) * HASH_MUL_S;
    h ^= h >> HASH_SHIFT_A;
    h = h * HASH_MUL_F;
    h ^= h >> 16;
    return int'(h[7:0]);
  endfunction

  function automatic int octave_value(int x, int z, int grid);
    int cx, cz, fx, fz, top, bot;
    cx = x / grid;
    cz = z / grid;
    fx = x - cx * grid;
    fz = z - cz * grid;
    top = lattice_byte(cx, cz) * (grid - fx) + lattice_byte(cx + 1, cz) * fx;
    bot = lattice_byte(cx, cz + 1) * (grid - fx) + lattice_byte(cx + 1, cz + 1) * fx;
    return (top * (grid - fz) + bot * fz) / (grid * grid);
  endfunction

  function automatic int column_height(int x, int z);
    int n, amp, h;
    n = (octave_value(x, z, 32) * 2 + octave_value(x, z, 8)) / 3;
    amp = world_h / 6;
    if (amp < 2) amp = 2;
    // signed division truncates toward zero
    h = world_h / 2 + ((n - int'(NOISE_MID)) * amp) / int'(NOISE_MID);
    if (h < 1) h = 1;
    if (h > world_h - 2) h = world_h - 2;
    return h;
  endfunction

  function automatic logic [2:0] predict_kind(coord_t c);
    int x, y, z, h, sea;
    x = int'(c.x);
    y = int'(c.y);
    z = int'(c.z);
    sea = world_h / 2;
    if (x >= world_w || y >= world_h || z >= world_l) return KIND_AIR;
    h = column_height(x, z);
    if (y == 0) return KIND_BEDROCK;
    if (y > h) return (y <= sea) ? KIND_WATER : KIND_AIR;
    if (y == h) return (h < sea) ? KIND_SAND : KIND_GRASS;
    if (y >= h - 3) return KIND_DIRT;
    return KIND_STONE;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // driver: record each transfer, then load the next coordinate or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_now.at = '{in_coord_x, in_coord_y, in_coord_z};
        due_now.kind = predict_kind(due_now.at);
        kinds_due.push_back(due_now);
        sent_count++;
      end
      if (!start || !busy) begin
        if (coords_pending.size() != 0 &&
            ((sent_count >= 400 && sent_count < 600) || $urandom_range(99) >= 32)) begin
          next_coord = coords_pending.pop_front();
          start <= 1'b1;
          in_coord_x <= next_coord.x;
          in_coord_y <= next_coord.y;
          in_coord_z <= next_coord.z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe must match the oldest prediction
  kind_due_t seen_due;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (kinds_due.size() == 0) begin
        flag_mismatch($sformatf("result kind %0d with nothing outstanding", out_block_kind));
      end else begin
        seen_due = kinds_due.pop_front();
        if (out_block_kind !== seen_due.kind)
          flag_mismatch($sformatf("(%0d,%0d,%0d) block_kind got %0d want %0d",
                                  seen_due.at.x, seen_due.at.y, seen_due.at.z,
                                  out_block_kind, seen_due.kind));
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SEED:   terrain_seed = value;
      CFG_WIDTH:  world_w = int'(value[8:0]);
      CFG_HEIGHT: world_h = int'(value[8:0]);
      CFG_LENGTH: world_l = int'(value[8:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_coord(int x, int y, int z);
    coord_t c;
    c.x = 8'((x < 0) ? 0 : (x > 255) ? 255 : x);
    c.y = 8'((y < 0) ? 0 : (y > 255) ? 255 : y);
    c.z = 8'((z < 0) ? 0 : (z > 255) ? 255 : z);
    coords_pending.push_back(c);
  endtask

  // walk a column through the stone, dirt, surface and above-surface layer rules
  task automatic push_column(int x, int z);
    int h, sea;
    h = column_height(x, z);
    sea = world_h / 2;
    push_coord(x, h - 4, z);
    push_coord(x, h - 3, z);
    push_coord(x, h, z);
    push_coord(x, h + 1, z);
    push_coord(x, sea, z);
    push_coord(x, sea + 1, z);
  endtask

  task automatic find_column(bit want_low, output int fx, output int fz);
    fx = 0;
    fz = 0;
    for (int z = 0; z < 256; z += 5) begin
      for (int x = 0; x < 256; x += 5) begin
        if ((column_height(x, z) < world_h / 2) == want_low) begin
          fx = x;
          fz = z;
          return;
        end
      end
    end
  endtask

  task automatic push_random_coord();
    int xl, yl, zl, x, y, z;
    xl = (world_w > 256) ? 256 : world_w;
    yl = (world_h > 256) ? 256 : world_h;
    zl = (world_l > 256) ? 256 : world_l;
    if (xl == 0 || yl == 0 || zl == 0 || $urandom_range(99) < 10) begin
      push_coord($urandom_range(255), $urandom_range(255), $urandom_range(255));
    end else begin
      x = $urandom_range(xl - 1);
      z = $urandom_range(zl - 1);
      case ($urandom_range(3))
        0, 1: y = column_height(x, z) - 6 + $urandom_range(8);
        2: y = $urandom_range(yl - 1);
        default: y = $urandom_range(1) ? 0 : yl - 1 + $urandom_range(1);
      endcase
      push_coord(x, y, z);
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (coords_pending.size() != 0 || start || kinds_due.size() != 0);
  endtask

  task automatic run_random(int count);
    repeat (count) push_random_coord();
    drain();
  endtask

  initial begin
    int cx, cz;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: corners, world edge, one low and one high column
    push_coord(0, 0, 0);
    push_coord(255, 0, 255);
    push_coord(255, 63, 255);
    push_coord(255, 255, 255);
    find_column(1'b1, cx, cz);
    push_column(cx, cz);
    find_column(1'b0, cx, cz);
    push_column(cx, cz);
    drain();
    run_random(150);

    write_reg(CFG_SEED, 16'hffff);
    write_reg(CFG_WIDTH, 16'd256);
    write_reg(CFG_HEIGHT, 16'd256);
    write_reg(CFG_LENGTH, 16'd256);
    run_random(150);

    // one-block world
    write_reg(CFG_SEED, 16'd0);
    write_reg(CFG_WIDTH, 16'd1);
    write_reg(CFG_HEIGHT, 16'd1);
    write_reg(CFG_LENGTH, 16'd1);
    run_random(40);

    // height 2 clamps the column to zero; upper data bits must be dropped
    write_reg(CFG_SEED, 16'($urandom));
    write_reg(CFG_WIDTH, 16'hfe03);
    write_reg(CFG_HEIGHT, 16'h8002);
    write_reg(CFG_LENGTH, 16'd5);
    run_random(80);

    write_reg(CFG_WIDTH, 16'h01ff);
    write_reg(CFG_HEIGHT, 16'h01ff);
    write_reg(CFG_LENGTH, 16'd300);
    run_random(150);

    // empty world
    write_reg(CFG_WIDTH, 16'd0);
    write_reg(CFG_HEIGHT, 16'd0);
    write_reg(CFG_LENGTH, 16'd0);
    run_random(40);

    repeat (4) begin
      write_reg(CFG_SEED, 16'($urandom));
      write_reg(CFG_WIDTH, {7'($urandom), 9'($urandom_range(1, 300))});
      write_reg(CFG_HEIGHT, {7'($urandom),
                             9'($urandom_range(1) ? $urandom_range(3, 16)
                                                  : $urandom_range(1, 256))});
      write_reg(CFG_LENGTH, {7'($urandom), 9'($urandom_range(1, 300))});
      run_random(170);
    end

    repeat (20) @(posedge clk);
    if (kinds_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", kinds_due.size()));
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tbg_pkg.sv
hw/rtl/tbg_lattice_hash.sv
hw/rtl/tbg_noise.sv
hw/rtl/tbg_height.sv
hw/rtl/terrain_block_generator.sv
hw/rtl/tbg_checker.sv
test/testbench.sv
